@@ src/lrg_pkg.sv @@
package lrg_pkg;

  localparam int VAL_W     = 48;
  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 24;
  localparam int PERIOD_W  = 16;
  localparam int CFG_W     = 16;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam int DVD_W = VAL_W + 1;
  localparam int DVS_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(20);

  localparam logic [VAL_W-1:0] FRAC_MASK = (VAL_W'(1) << FRAC_BITS) - VAL_W'(1);
  localparam logic [VAL_W-1:0] FRAC_ONE  = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_TARGET = 3'd0,
    KIND_TICK   = 3'd1,
    KIND_STOP   = 3'd2,
    KIND_SET    = 3'd3,
    KIND_TIME   = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD  = 1'd0,
    CFG_INTEGER_MODE = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV1,
    ST_DIV2,
    ST_ADV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  // Truncates a fixed-point value toward zero to a whole number.
  function automatic logic [VAL_W-1:0] whole(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] kept;
    kept = v & ~FRAC_MASK;
    if (v[VAL_W-1] && ((v & FRAC_MASK) != '0)) begin
      whole = kept + FRAC_ONE;
    end else begin
      whole = kept;
    end
  endfunction

endpackage

@@ src/linear_ramp_generator.sv @@
// Control-rate line generator. Kind 4 stores a pending ramp time; a new
// target (kind 0) then ramps from the current point in steps of the tick
// period, emitting the first step at once, and each tick (kind 1) emits the
// next step until the exact target goes out with last set. Without a pending
// time a new target is emitted at once with last set. Stop, set-silently and
// set-time produce no transaction. Each input transaction is taken alone:
// in_stall is high from acceptance until the result is in the output
// register. Between one acceptance and the next, silent kinds and a tick
// with no ramp running pass through EXEC alone, a jump through EXEC and
// OUT, and a ramp tick through EXEC, ADV and OUT, waiting in OUT while the
// output is stalled. A new target that starts a ramp runs two divisions on
// one shared radix-2 divider, one quotient bit per cycle: TIME_BITS bits
// for the step count and VAL_W+1 bits for the increment. The user writes
// configuration only while the block is idle; the block does not check it.
module linear_ramp_generator import lrg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic signed [VAL_W-1:0]    in_value,
  input  logic [TIME_BITS-1:0]       in_ramp_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VAL_W-1:0]    out_level,
  output logic                       out_last
);

  state_t state_r, state_nxt;

  logic [PERIOD_W-1:0]  tick_period_r, tick_period_nxt;
  logic                 integer_mode_r, integer_mode_nxt;
  logic [VAL_W-1:0]     goal_r, goal_nxt;
  logic [VAL_W-1:0]     current_r, current_nxt;
  logic [VAL_W-1:0]     increment_r, increment_nxt;
  logic [TIME_BITS-1:0] steps_left_r, steps_left_nxt;
  logic [TIME_BITS-1:0] pending_r, pending_nxt;
  logic                 active_r, active_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [VAL_W-1:0]     value_r, value_nxt;
  logic [VAL_W-1:0]     target_r, target_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [DVD_W-1:0]     dist_r, dist_nxt;
  logic [VAL_W-1:0]     res_r, res_nxt;
  logic                 res_last_r, res_last_nxt;
  logic [VAL_W-1:0]     out_level_r, out_level_nxt;
  logic                 out_last_r, out_last_nxt;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [DVD_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic [DVD_W-1:0]     div_quotient;

  logic                 accept;
  logic [VAL_W-1:0]     start_pt;
  logic [TIME_BITS-1:0] steps_dec;
  logic [VAL_W-1:0]     step_sum;
  logic [DVD_W-1:0]     neg_q;

  lrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quotient (div_quotient)
  );

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt        = state_r;
    tick_period_nxt  = tick_period_r;
    integer_mode_nxt = integer_mode_r;
    goal_nxt         = goal_r;
    current_nxt      = current_r;
    increment_nxt    = increment_r;
    steps_left_nxt   = steps_left_r;
    pending_nxt      = pending_r;
    active_nxt       = active_r;
    out_valid_nxt    = out_valid_r;
    kind_nxt         = kind_r;
    value_nxt        = value_r;
    target_nxt       = target_r;
    time_nxt         = time_r;
    dist_nxt         = dist_r;
    res_nxt          = res_r;
    res_last_nxt     = res_last_r;
    out_level_nxt    = out_level_r;
    out_last_nxt     = out_last_r;
    div_req.start    = 1'b0;
    div_req.nbits    = CNT_W'(DVD_W);
    div_dividend     = {pending_r - TIME_BITS'(1), {(DVD_W-TIME_BITS){1'b0}}};
    div_divisor      = DVS_W'(tick_period_r);
    start_pt         = (steps_left_r != '0) ? current_r : goal_r;
    steps_dec        = (steps_left_r != '0) ? steps_left_r - TIME_BITS'(1) : '0;
    step_sum         = current_r + increment_r;
    neg_q            = '0 - div_quotient;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD: begin
          tick_period_nxt = (cfg_wdata[PERIOD_W-1:0] != '0) ?
                            cfg_wdata[PERIOD_W-1:0] : DEFAULT_PERIOD;
        end
        CFG_INTEGER_MODE: begin
          integer_mode_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          value_nxt  = in_value;
          target_nxt = integer_mode_r ? whole(in_value) : in_value;
          time_nxt   = in_ramp_time;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (kind_r)
          KIND_TARGET: begin
            active_nxt = 1'b0;
            goal_nxt   = target_r;
            if (pending_r != '0) begin
              dist_nxt      = {target_r[VAL_W-1], target_r} -
                              {start_pt[VAL_W-1], start_pt};
              current_nxt   = start_pt;
              pending_nxt   = '0;
              div_req.start = 1'b1;
              div_req.nbits = CNT_W'(TIME_BITS);
              state_nxt     = ST_DIV1;
            end else begin
              steps_left_nxt = '0;
              res_nxt        = target_r;
              res_last_nxt   = 1'b1;
              state_nxt      = ST_OUT;
            end
          end
          KIND_TICK: begin
            if (active_r) begin
              state_nxt = ST_ADV;
            end
          end
          KIND_STOP: begin
            steps_left_nxt = '0;
            goal_nxt       = current_r;
            active_nxt     = 1'b0;
          end
          KIND_SET: begin
            active_nxt     = 1'b0;
            goal_nxt       = value_r;
            steps_left_nxt = '0;
          end
          KIND_TIME: begin
            pending_nxt = time_r;
          end
          default: begin
          end
        endcase
      end
      ST_DIV1: begin
        div_dividend = dist_r[DVD_W-1] ? ('0 - dist_r) : dist_r;
        div_divisor  = DVS_W'(div_quotient[TIME_BITS-1:0] + TIME_BITS'(1));
        if (div_rsp.done) begin
          steps_left_nxt = div_quotient[TIME_BITS-1:0] + TIME_BITS'(1);
          div_req.start  = 1'b1;
          div_req.nbits  = CNT_W'(DVD_W);
          state_nxt      = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          if (!dist_r[DVD_W-1]) begin
            increment_nxt = (div_quotient[DVD_W-1:VAL_W-1] != '0) ?
                            VAL_MAX : div_quotient[VAL_W-1:0];
          end else if (div_quotient[DVD_W-1] ||
                       (div_quotient[VAL_W-1] && (div_quotient[VAL_W-2:0] != '0))) begin
            increment_nxt = VAL_MIN;
          end else begin
            increment_nxt = neg_q[VAL_W-1:0];
          end
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        steps_left_nxt = steps_dec;
        if (steps_dec != '0) begin
          current_nxt  = step_sum;
          active_nxt   = 1'b1;
          res_nxt      = step_sum;
          res_last_nxt = 1'b0;
        end else begin
          active_nxt   = 1'b0;
          res_nxt      = goal_r;
          res_last_nxt = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = integer_mode_r ? whole(res_r) : res_r;
          out_last_nxt  = res_last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      tick_period_r  <= DEFAULT_PERIOD;
      integer_mode_r <= 1'b1;
      goal_r         <= '0;
      current_r      <= '0;
      increment_r    <= '0;
      steps_left_r   <= '0;
      pending_r      <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      tick_period_r  <= tick_period_nxt;
      integer_mode_r <= integer_mode_nxt;
      goal_r         <= goal_nxt;
      current_r      <= current_nxt;
      increment_r    <= increment_nxt;
      steps_left_r   <= steps_left_nxt;
      pending_r      <= pending_nxt;
      active_r       <= active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    value_r     <= value_nxt;
    target_r    <= target_nxt;
    time_r      <= time_nxt;
    dist_r      <= dist_nxt;
    res_r       <= res_nxt;
    res_last_r  <= res_last_nxt;
    out_level_r <= out_level_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

endmodule

@@ src/lrg_div.sv @@
module lrg_div import lrg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_rsp_t         rsp,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  // Restoring division, one quotient bit per cycle. The dividend enters
  // left-aligned when fewer than DVD_W quotient bits are wanted.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[DVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = req.nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (divisor != '0) && (req.nbits != '0))
    else $error("divider started with zero divisor or length");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished division");

  a_count_runs: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start && (cnt_r != CNT_W'(1)) |=> busy_r && (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("divider count out of step");
`endif

endmodule
